// ===== rtl/core/rlbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbd_pkg
// Shared widths, result codes, types and helpers of the run-length bitmap
// decoder.
// ----------------------------------------------------------------------------
package rlbd_pkg;

   localparam int MAX_DIM  = 4096;
   localparam int DIM_W    = 13;
   localparam int PIX_W    = 25;
   localparam int RUN_W    = 14;
   localparam int COLOR_W  = 8;
   localparam int OFF_W    = 24;
   localparam int Q_DEPTH  = 4;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int CNT_W    = $clog2(PIX_W + 1);
   localparam int CSR_ADDR_W = 2;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_OBJ_WIDTH   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OBJ_HEIGHT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STRICT_MODE = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_RUN      = 2'd0;
   localparam logic [1:0] KIND_LINE_END = 2'd1;
   localparam logic [1:0] KIND_DONE_OK  = 2'd2;
   localparam logic [1:0] KIND_DONE_ERR = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_LINE_LEN = 2'd1;
   localparam logic [1:0] ERR_SHORT    = 2'd2;

   localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

   // One parsed code handed from the parser to the executor
   typedef struct packed {
      logic               has_code;
      logic [RUN_W-1:0]   run;
      logic [COLOR_W-1:0] color;
      logic               last_byte;
   } code_entry_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [COLOR_W-1:0] color;
      logic [RUN_W-1:0]   run;
      logic [OFF_W-1:0]   start;
      logic [1:0]         err;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
      logic rem_zero;
   } mod_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   function automatic logic [OFF_W-1:0] sat_offset(input logic [PIX_W-1:0] p);
      logic [OFF_W-1:0] r;
      r = p[OFF_W-1:0];
      if (p > {1'b0, OFF_MAX}) begin
         r = OFF_MAX;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/rlbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbd_front
// Byte parser: collects single-pixel bytes and long codes into whole codes
// and pushes one queue entry per completed code or final byte.
// ----------------------------------------------------------------------------
module rlbd_front
   import rlbd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_valid,
   input  logic [7:0]         byte_data,
   input  logic               byte_last,
   input  logic               q_full,
   output logic               byte_ready,
   output logic               q_push,
   output code_entry_type     q_entry
);

   localparam logic [1:0] PH_COLOR = 2'd0;
   localparam logic [1:0] PH_FLAGS = 2'd1;
   localparam logic [1:0] PH_LEN2  = 2'd2;
   localparam logic [1:0] PH_CBYTE = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic             has_color_ff, has_color_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             take;
   logic             emit;
   logic [RUN_W-1:0] emit_run;
   logic [COLOR_W-1:0] emit_color;

   assign byte_ready = !q_full;
   assign take       = byte_valid && !q_full;

   always_comb begin
      phase_in     = phase_ff;
      has_color_in = has_color_ff;
      run_in       = run_ff;
      emit         = 1'b0;
      emit_run     = run_ff;
      emit_color   = '0;
      if (take) begin
         case (phase_ff)
            PH_COLOR: begin
               if (byte_data != 8'h00) begin
                  emit       = 1'b1;
                  emit_run   = RUN_W'(1);
                  emit_color = byte_data;
               end else begin
                  phase_in = PH_FLAGS;
               end
            end
            PH_FLAGS: begin
               has_color_in = byte_data[7];
               run_in       = RUN_W'(byte_data[5:0]);
               if (byte_data[6]) begin
                  phase_in = PH_LEN2;
               end else if (byte_data[7]) begin
                  phase_in = PH_CBYTE;
               end else begin
                  emit     = 1'b1;
                  emit_run = RUN_W'(byte_data[5:0]);
                  phase_in = PH_COLOR;
               end
            end
            PH_LEN2: begin
               run_in = {run_ff[5:0], byte_data};
               if (has_color_ff) begin
                  phase_in = PH_CBYTE;
               end else begin
                  emit     = 1'b1;
                  emit_run = {run_ff[5:0], byte_data};
                  phase_in = PH_COLOR;
               end
            end
            default: begin
               emit       = 1'b1;
               emit_run   = run_ff;
               emit_color = byte_data;
               phase_in   = PH_COLOR;
            end
         endcase
         // drop any half-parsed code at the end of the object
         if (byte_last) begin
            phase_in     = PH_COLOR;
            has_color_in = 1'b0;
            run_in       = '0;
         end
      end
   end

   assign q_push             = take && (emit || byte_last);
   assign q_entry.has_code   = emit;
   assign q_entry.run        = emit_run;
   assign q_entry.color      = emit_color;
   assign q_entry.last_byte  = byte_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COLOR;
         has_color_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         has_color_ff <= has_color_in;
         run_ff       <= run_in;
      end
   end

endmodule

// ===== rtl/core/rlbd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbd_queue
// Small first-in first-out queue of parsed codes between parser and executor.
// ----------------------------------------------------------------------------
module rlbd_queue
   import rlbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  code_entry_type push_entry,
   input  logic           pop,
   output logic           full,
   output logic           not_empty,
   output code_entry_type head
);

   code_entry_type       store_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (Q_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (Q_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/rlbd_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbd_mod
// Bit-serial restoring remainder: pixel count modulo object width, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module rlbd_mod
   import rlbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [PIX_W-1:0] dividend,
   input  logic [DIM_W-1:0] divisor,
   output mod_status_type   status
);

   logic [PIX_W-1:0] num_ff, num_in;
   logic [DIM_W-1:0] div_ff, div_in;
   logic [DIM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIM_W:0]   trial;

   assign trial = {rem_ff, num_ff[PIX_W-1]};

   always_comb begin
      num_in   = num_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      if (start) begin
         num_in   = dividend;
         div_in   = divisor;
         rem_in   = '0;
         count_in = CNT_W'(PIX_W);
      end else if (count_ff != '0) begin
         // shift in the next bit, subtract the divisor where it fits
         num_in   = {num_ff[PIX_W-2:0], 1'b0};
         rem_in   = (trial >= {1'b0, div_ff}) ? DIM_W'(trial - {1'b0, div_ff})
                                              : trial[DIM_W-1:0];
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign status.busy     = (count_ff != '0);
   assign status.rem_zero = (rem_ff == '0);

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/rlbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbd_back
// Code executor: places runs in the bitmap, checks line ends, reports the
// object outcome and holds the result register.
// ----------------------------------------------------------------------------
module rlbd_back
   import rlbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [DIM_W-1:0] height_eff,
   input  logic [PIX_W-1:0] area,
   input  logic             strict_mode,
   input  logic             q_not_empty,
   input  code_entry_type   q_head,
   output logic             q_pop,
   output logic             mod_start,
   output logic [PIX_W-1:0] mod_dividend,
   input  mod_status_type   mod_status,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_item_type     rsp_item
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MOD   = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [DIM_W-1:0] lines_ff, lines_in;
   logic             aborted_ff, aborted_in;
   logic             final_pend_ff, final_pend_in;
   logic             valid_ff, valid_in;
   rsp_item_type     item_ff, item_in;
   logic             out_free;
   logic             gate;
   logic [PIX_W:0]   sum;

   assign out_free     = !valid_ff || rsp_ready;
   assign gate         = !aborted_ff && (lines_ff < height_eff);
   assign sum          = {1'b0, pix_ff} + (PIX_W+1)'(q_head.run);
   assign mod_dividend = pix_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_item     = item_ff;

   always_comb begin
      state_in      = state_ff;
      pix_in        = pix_ff;
      lines_in      = lines_ff;
      aborted_in    = aborted_ff;
      final_pend_in = final_pend_ff;
      valid_in      = valid_ff && !rsp_ready;
      item_in       = item_ff;
      q_pop         = 1'b0;
      mod_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty && out_free) begin
               q_pop = 1'b1;
               if (q_head.has_code && gate && (q_head.run != '0)) begin
                  // drop runs that overflow the bitmap
                  if (sum <= {1'b0, area}) begin
                     valid_in = 1'b1;
                     item_in  = '{kind: KIND_RUN, color: q_head.color,
                                  run: q_head.run, start: pix_ff[OFF_W-1:0],
                                  err: ERR_NONE, last: 1'b0};
                     pix_in   = sum[PIX_W-1:0];
                  end
                  if (q_head.last_byte) begin
                     state_in = ST_FINAL;
                  end
               end else if (q_head.has_code && gate) begin
                  mod_start     = 1'b1;
                  final_pend_in = q_head.last_byte;
                  state_in      = ST_MOD;
               end else if (q_head.last_byte) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_MOD: begin
            if (!mod_status.busy && out_free) begin
               valid_in = 1'b1;
               item_in  = '{kind: KIND_LINE_END, color: '0, run: '0,
                            start: sat_offset(pix_ff), err: ERR_NONE, last: 1'b0};
               lines_in = lines_ff + DIM_W'(1);
               if (!mod_status.rem_zero) begin
                  item_in.err = ERR_LINE_LEN;
                  if (strict_mode) begin
                     item_in.kind = KIND_DONE_ERR;
                     item_in.last = 1'b1;
                     aborted_in   = 1'b1;
                     lines_in     = lines_ff;
                  end
               end
               state_in = final_pend_ff ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (aborted_ff || out_free) begin
               if (!aborted_ff) begin
                  valid_in = 1'b1;
                  item_in  = '{kind: KIND_DONE_OK, color: '0, run: '0,
                               start: sat_offset(pix_ff), err: ERR_NONE,
                               last: 1'b1};
                  if (pix_ff < area) begin
                     item_in.kind = KIND_DONE_ERR;
                     item_in.err  = ERR_SHORT;
                  end
               end
               pix_in     = '0;
               lines_in   = '0;
               aborted_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      final_pend_ff <= final_pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pix_ff     <= '0;
         lines_ff   <= '0;
         aborted_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pix_ff     <= pix_in;
         lines_ff   <= lines_in;
         aborted_ff <= aborted_in;
         valid_ff   <= valid_in;
      end
   end

endmodule

// ===== rtl/core/subtitle_rle_bitmap_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_rle_bitmap_decoder_top
// Run-length bitmap decoder for one subtitle object: coded bytes in, runs of
// palette indices, line ends and a completion report out.
// ----------------------------------------------------------------------------
// The parser takes one coded byte per clock whenever its four-entry code
// queue has room, so the input side stalls only when the executor falls
// behind. The executor retires a pixel run straight from idle. A line end
// makes it wait while the pixel count is reduced modulo the object width
// by a bit-serial remainder unit that works through the 25 count bits in
// turn. The final report of an object has a state of its own. Results leave
// through a single output register, and the executor takes no further code
// from the queue while a result waits there unaccepted.
// The user must write object width, height and strict mode through the
// csr_ port only while no object is in flight; the block itself does not
// enforce this. Zero dimensions act as 1, oversized ones as 4096.
// ----------------------------------------------------------------------------
module subtitle_rle_bitmap_decoder_top
   import rlbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input transaction
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] code_byte
   input  logic                  req_tlast,   // final_byte
   // result transaction
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // [7:0] color_index, [21:8] run_length,
                                              // [45:22] start_offset, [47:46] error_code
   output logic [1:0]            rsp_tuser,   // [1:0] kind
   output logic                  rsp_tlast,   // last_result
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata
);

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic               strict_ff, strict_in;
   logic [DIM_W-1:0]   width_eff, height_eff;
   logic [2*DIM_W-1:0] area_prod;
   logic [PIX_W-1:0]   area_ff;

   logic               q_push, q_pop, q_full, q_not_empty;
   code_entry_type     q_entry, q_head;
   logic               mod_start;
   logic [PIX_W-1:0]   mod_dividend;
   mod_status_type     mod_status;
   rsp_item_type       rsp_item;

   // Hold the registers; write only the one addressed
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      strict_in = strict_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_OBJ_WIDTH:   width_in  = csr_wdata;
            CSR_OBJ_HEIGHT:  height_in = csr_wdata;
            CSR_STRICT_MODE: strict_in = csr_wdata[0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         strict_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         strict_ff <= strict_in;
      end
   end

   assign width_eff  = clamp_dim(width_ff);
   assign height_eff = clamp_dim(height_ff);
   assign area_prod  = width_eff * height_eff;

   // Bitmap area, registered after the multiplier
   always_ff @(posedge clock) begin
      area_ff <= area_prod[PIX_W-1:0];
   end

   rlbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .q_full     (q_full),
      .byte_ready (req_tready),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   rlbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   rlbd_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .divisor  (width_eff),
      .status   (mod_status)
   );

   rlbd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .height_eff   (height_eff),
      .area         (area_ff),
      .strict_mode  (strict_ff),
      .q_not_empty  (q_not_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .mod_start    (mod_start),
      .mod_dividend (mod_dividend),
      .mod_status   (mod_status),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_item     (rsp_item)
   );

   // Pack the result fields, error code in the top bits and color in the lowest
   assign rsp_tdata = {rsp_item.err, rsp_item.start, rsp_item.run, rsp_item.color};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

endmodule
